// ===== rtl/core/smd_pkg.sv =====
// smd_pkg: types, codes and constants for the swath min decimator
// no dependencies
`timescale 1ns / 1ps
package smd_pkg;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_SAVE   = 2'd1;
    localparam logic [1:0] CMD_RESET  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [2:0] KIND_EMIT    = 3'd0;
    localparam logic [2:0] KIND_NONE    = 3'd1;
    localparam logic [2:0] KIND_DUP     = 3'd2;
    localparam logic [2:0] KIND_SIDE    = 3'd3;
    localparam logic [2:0] KIND_PENDING = 3'd4;
    localparam logic [2:0] KIND_LRESET  = 3'd5;

    localparam logic [0:0] CFG_INTERVAL = 1'd0;
    localparam logic [0:0] CFG_SIDE     = 1'd1;

    localparam logic [1:0] SIDE_PORT    = 2'd0;
    localparam logic [1:0] SIDE_STBD    = 2'd1;
    localparam logic [1:0] SIDE_UNKNOWN = 2'd2;

    localparam logic [31:0] INTERVAL_RESET = 32'd2560;
    localparam logic [1:0]  SIDE_RESET     = SIDE_UNKNOWN;

    localparam int HALF_TURN  = 11520;
    localparam int FULL_TURN  = 23040;
    localparam int TURN_LIMIT = 1280;

    localparam int ROOT_BITS = 34;
    localparam int SQ_BITS   = 66;
    localparam int TRAV_BITS = 40;

    typedef struct packed {
        logic [1:0]         command;
        logic [19:0]        width_stbd;
        logic [19:0]        width_port;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [14:0]        course;
        logic [19:0]        sounding;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic               final_item;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic [14:0]        out_course;
        logic [19:0]        out_width_stbd;
        logic [19:0]        out_width_port;
        logic [19:0]        out_sounding;
    } out_beat_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [14:0]        course;
        logic [19:0]        ws;
        logic [19:0]        wp;
        logic [19:0]        depth;
    } rec_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input beat
        logic sq_x;      // take |dx| and |dy|
        logic sq_y;      // square both and sum
        logic root_init;
        logic root_step;
        logic decide;    // evaluate beat and update state
        logic out_take;  // first result consumed, second moves up
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_add;
        logic is_nop;
        logic root_done;
        logic two_results;
    } dp_stat_t;

endpackage

// ===== rtl/core/swath_min_decimator_unit.sv =====
// swath_min_decimator_unit: top level, joins sequencer and datapath
// depends on smd_pkg, smd_ctrl, smd_datapath
// flow: add beat first result follows magnitude, squares, 34 root steps and
// decide; save, reset and duplicate beats go straight to decide
// occupancy: one beat in flight, set by the bit-serial square root; a new beat
// is taken only after all results of the last one have been consumed
// reset: asynchronous active low, control, config and line state registers back to power-on values, no sweep
`timescale 1ns / 1ps
module swath_min_decimator_unit
    import smd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_beat_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_beat_t   out_data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer: one beat at a time, up to two result beats
    smd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: config registers, line state, distance unit
    smd_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_beat   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_beat  (out_data)
    );

endmodule

// ===== rtl/core/smd_ctrl.sv =====
// smd_ctrl: sequencer for one beat at a time
// depends on smd_pkg
`timescale 1ns / 1ps
module smd_ctrl
    import smd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SQX    = 7'b0000010,
        ST_SQY    = 7'b0000100,
        ST_ROOT   = 7'b0001000,
        ST_DECIDE = 7'b0010000,
        ST_OUT1   = 7'b0100000,
        ST_OUT2   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   two_reg, two_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT1) || (state_reg == ST_OUT2);

    always_comb
    begin
        state_next = state_reg;
        two_next   = two_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SQX;
                end
            end
            ST_SQX:
            begin
                if (stat.is_nop)
                    state_next = ST_IDLE;
                else if (stat.is_add)
                begin
                    cmd.sq_x   = 1'b1;
                    state_next = ST_SQY;
                end
                else
                    state_next = ST_DECIDE;
            end
            ST_SQY:
            begin
                cmd.sq_y      = 1'b1;
                cmd.root_init = 1'b1;
                state_next    = ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (stat.root_done)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                two_next   = stat.two_results;
                state_next = ST_OUT1;
            end
            ST_OUT1:
            begin
                if (out_ready)
                begin
                    cmd.out_take = two_reg;
                    state_next   = two_reg ? ST_OUT2 : ST_IDLE;
                end
            end
            ST_OUT2:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            two_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            two_reg   <= two_next;
        end
    end

endmodule

// ===== rtl/core/smd_datapath.sv =====
// smd_datapath: squares, bit-serial root, interval and emit state
// depends on smd_pkg
`timescale 1ns / 1ps
module smd_datapath
    import smd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  in_beat_t    in_beat,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    output out_beat_t   out_beat
);

    logic [31:0] interval_reg;
    logic [1:0]  side_reg;

    in_beat_t    beat_reg;
    logic signed [31:0] px_reg, py_reg;
    logic [14:0] pc_reg;
    logic        have_reg, nonempty_reg, emitted_any_reg;
    logic [TRAV_BITS-1:0] trav_reg;
    rec_t        first_reg, latest_reg, least_p_reg, least_s_reg;
    logic [19:0] lw_p_reg, lw_s_reg;
    logic        lf_p_reg, lf_s_reg;
    logic signed [31:0] ex_reg, ey_reg;
    logic [14:0] ec_reg;

    logic [32:0] ax_reg, ay_reg;
    logic [SQ_BITS-1:0] rem_reg;
    logic [ROOT_BITS-1:0] root_reg;
    logic [5:0]  bit_reg;
    out_beat_t   o1_reg, o2_reg;

    rec_t cur;
    assign cur = '{x: beat_reg.pos_x, y: beat_reg.pos_y, course: beat_reg.course,
                   ws: beat_reg.width_stbd, wp: beat_reg.width_port,
                   depth: beat_reg.sounding};

    logic signed [32:0] dx, dy;
    assign dx = 33'($signed(beat_reg.pos_x)) - 33'(px_reg);
    assign dy = 33'($signed(beat_reg.pos_y)) - 33'(py_reg);

    logic is_dup;
    assign is_dup = (beat_reg.pos_x == px_reg) && (beat_reg.pos_y == py_reg) &&
                    (beat_reg.course == pc_reg);

    // restoring root step: trial = (root<<bit... ) via remainder form
    logic [SQ_BITS+1:0] trial;
    logic [SQ_BITS+1:0] rem_ext;
    assign trial   = ((SQ_BITS+2)'(root_reg) << (bit_reg + 6'd1)) +
                     ((SQ_BITS+2)'(1) << (7'(bit_reg) << 1));
    assign rem_ext = (SQ_BITS+2)'(rem_reg);

    assign stat.is_add      = (beat_reg.command == CMD_ADD) && !is_dup;
    assign stat.is_nop      = (beat_reg.command == CMD_UNUSED);
    assign stat.root_done   = (bit_reg == 6'd0);

    function automatic out_beat_t mk(input logic [2:0] k, input rec_t r, input logic e);
        out_beat_t o;
        o.kind           = k;
        o.final_item     = 1'b0;
        o.out_x          = e ? r.x : '0;
        o.out_y          = e ? r.y : '0;
        o.out_course     = e ? r.course : '0;
        o.out_width_stbd = e ? r.ws : '0;
        o.out_width_port = e ? r.wp : '0;
        o.out_sounding   = e ? r.depth : '0;
        return o;
    endfunction

    // decision logic for add, and result beats for every command
    rec_t n_first, n_lp, n_ls;
    logic [19:0] n_lwp, n_lws;
    logic n_lfp, n_lfs;
    logic [TRAV_BITS:0] tsum;
    logic [TRAV_BITS-1:0] tsat;
    logic signed [16:0] turn;
    logic turn_hit, closes, side_ok, lf_sel, two;
    rec_t least_sel;
    out_beat_t o1_next, o2_next;

    always_comb
    begin
        n_first = first_reg; n_lp = least_p_reg; n_ls = least_s_reg;
        n_lwp = lw_p_reg; n_lws = lw_s_reg; n_lfp = lf_p_reg; n_lfs = lf_s_reg;
        if (!nonempty_reg)
        begin
            n_first = cur; n_lp = cur; n_ls = cur;
            n_lwp = cur.wp; n_lws = cur.ws; n_lfp = 1'b1; n_lfs = 1'b1;
        end
        else
        begin
            if (cur.wp < lw_p_reg)
            begin
                n_lp = cur; n_lwp = cur.wp; n_lfp = 1'b0;
            end
            if (cur.ws < lw_s_reg)
            begin
                n_ls = cur; n_lws = cur.ws; n_lfs = 1'b0;
            end
        end
        tsum = (TRAV_BITS+1)'(trav_reg) + (TRAV_BITS+1)'(root_reg);
        tsat = tsum[TRAV_BITS] ? '1 : tsum[TRAV_BITS-1:0];
        closes  = have_reg && (tsat >= TRAV_BITS'(interval_reg));
        side_ok = (side_reg <= SIDE_STBD);
        turn = 17'(beat_reg.course) - 17'(ec_reg);
        if (turn > 17'sd11520)
            turn = turn - 17'sd23040;
        else if (turn <= -17'sd11520)
            turn = turn + 17'sd23040;
        turn_hit = have_reg && !closes && emitted_any_reg && side_ok &&
                   (((side_reg == SIDE_PORT) && (turn > 17'sd1280)) ||
                    ((side_reg == SIDE_STBD) && (turn < -17'sd1280)));
        lf_sel    = side_reg[0] ? n_lfs : n_lfp;
        least_sel = side_reg[0] ? n_ls : n_lp;
        two = stat.is_add && closes && side_ok && !emitted_any_reg && !lf_sel;

        o2_next = mk(KIND_EMIT, least_sel, 1'b1);
        o2_next.final_item = 1'b1;
        unique case (beat_reg.command)
            CMD_ADD:
            begin
                if (is_dup)
                    o1_next = mk(KIND_DUP, cur, 1'b0);
                else if (closes && !side_ok)
                    o1_next = mk(KIND_SIDE, cur, 1'b0);
                else if (closes)
                    o1_next = mk(KIND_EMIT, two ? first_reg : least_sel, 1'b1);
                else if (turn_hit)
                    o1_next = mk(KIND_EMIT, cur, 1'b1);
                else
                    o1_next = mk(KIND_NONE, cur, 1'b0);
            end
            CMD_SAVE:
            begin
                if (!(emitted_any_reg && nonempty_reg))
                    o1_next = mk(KIND_PENDING, cur, 1'b0);
                else if ((latest_reg.x != ex_reg) || (latest_reg.y != ey_reg))
                    o1_next = mk(KIND_EMIT, latest_reg, 1'b1);
                else
                    o1_next = mk(KIND_NONE, cur, 1'b0);
            end
            default: o1_next = mk(KIND_LRESET, cur, 1'b0);
        endcase
        o1_next.final_item = !two;
    end
    assign stat.two_results = two;

    assign out_beat = o1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg    <= INTERVAL_RESET;
            side_reg        <= SIDE_RESET;
            px_reg          <= '0;
            py_reg          <= '0;
            pc_reg          <= '0;
            have_reg        <= 1'b0;
            nonempty_reg    <= 1'b0;
            emitted_any_reg <= 1'b0;
            trav_reg        <= '0;
            lf_p_reg        <= 1'b1;
            lf_s_reg        <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_INTERVAL)
                    interval_reg <= cfg_data;
                else
                    side_reg <= cfg_data[1:0];
            end
            if (cmd.decide)
            begin
                unique case (beat_reg.command)
                    CMD_ADD:
                    begin
                        if (!is_dup)
                        begin
                            nonempty_reg <= 1'b1;
                            first_reg <= n_first; least_p_reg <= n_lp; least_s_reg <= n_ls;
                            lw_p_reg <= n_lwp; lw_s_reg <= n_lws;
                            lf_p_reg <= n_lfp; lf_s_reg <= n_lfs;
                            latest_reg <= cur;
                            if (have_reg)
                                trav_reg <= closes ? '0 : tsat;
                            if (!(closes && !side_ok))
                            begin
                                px_reg <= cur.x; py_reg <= cur.y; pc_reg <= cur.course;
                                have_reg <= 1'b1;
                            end
                            if (closes && side_ok)
                            begin
                                nonempty_reg <= 1'b0;
                                emitted_any_reg <= 1'b1;
                                ex_reg <= least_sel.x; ey_reg <= least_sel.y;
                                ec_reg <= least_sel.course;
                            end
                            else if (turn_hit)
                            begin
                                nonempty_reg <= 1'b0;
                                emitted_any_reg <= 1'b1;
                                ex_reg <= cur.x; ey_reg <= cur.y; ec_reg <= cur.course;
                            end
                        end
                    end
                    CMD_SAVE:
                    begin
                        if (emitted_any_reg && nonempty_reg &&
                            ((latest_reg.x != ex_reg) || (latest_reg.y != ey_reg)))
                        begin
                            ex_reg <= latest_reg.x; ey_reg <= latest_reg.y;
                            ec_reg <= latest_reg.course;
                        end
                    end
                    CMD_RESET:
                    begin
                        nonempty_reg <= 1'b0; emitted_any_reg <= 1'b0;
                        trav_reg <= '0; have_reg <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            beat_reg <= in_beat;
        if (cmd.sq_x)
        begin
            ax_reg  <= dx[32] ? 33'(-dx) : 33'(dx);
            ay_reg  <= dy[32] ? 33'(-dy) : 33'(dy);
        end
        if (cmd.sq_y)
            rem_reg <= {33'd0, ax_reg} * {33'd0, ax_reg} +
                       {33'd0, ay_reg} * {33'd0, ay_reg};
        if (cmd.root_init)
        begin
            root_reg <= '0;
            bit_reg  <= 6'(ROOT_BITS - 1);
        end
        if (cmd.root_step && !cmd.root_init)
        begin
            // root holds the upper bits found so far, aligned at bit position
            if (trial <= rem_ext)
            begin
                rem_reg  <= SQ_BITS'(rem_ext - trial);
                root_reg <= root_reg | (ROOT_BITS'(1) << bit_reg);
            end
            if (bit_reg != 6'd0)
                bit_reg <= bit_reg - 6'd1;
        end
        if (cmd.decide)
        begin
            o1_reg <= o1_next;
            o2_reg <= o2_next;
        end
        else if (cmd.out_take)
            o1_reg <= o2_reg;
    end

endmodule
